/* sv/uetd_pkg.sv */
// Package for the UART edge timestamp decoder.
// Holds the result word type, the push group, offset dividends and reset offsets.
// Depends on nothing.
package uetd_pkg;

	localparam int TimeWidth    = 32;
	localparam int BaudWidth    = 20;
	localparam int OffsetWidth  = 24;
	localparam int NumOffsets   = 9;
	localparam int DivSteps     = 24;
	localparam int StepWidth    = $clog2(DivSteps);
	localparam int IdxWidth     = $clog2(NumOffsets);
	localparam int ResetBaud    = 10400;
	localparam int SpacingLimit = 5;
	localparam int DefMaxBytes  = 256;

	localparam logic [OffsetWidth-1:0] OffsetDividend [NumOffsets] = '{
		24'd1500000, 24'd2500000, 24'd3500000, 24'd4500000, 24'd5500000,
		24'd6500000, 24'd7500000, 24'd8500000, 24'd9500000
	};

	localparam logic [OffsetWidth-1:0] ResetOffset [NumOffsets] = '{
		24'(1500000 / ResetBaud), 24'(2500000 / ResetBaud), 24'(3500000 / ResetBaud),
		24'(4500000 / ResetBaud), 24'(5500000 / ResetBaud), 24'(6500000 / ResetBaud),
		24'(7500000 / ResetBaud), 24'(8500000 / ResetBaud), 24'(9500000 / ResetBaud)
	};

	typedef struct packed {
		logic [7:0]           data_byte;
		logic                 byte_valid;
		logic                 end_of_capture;
		logic [TimeWidth-1:0] min_spacing;
		logic [TimeWidth-1:0] max_spacing;
		logic                 spacing_seen;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

/* sv/uetd_offset_div.sv */
// Serial restoring divider that recomputes the nine sample offsets from the baud rate.
// One quotient bit per cycle, the nine offsets one after another.
// Depends on uetd_pkg.
module uetd_offset_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [uetd_pkg::BaudWidth-1:0]     baud,
	output logic                               busy,
	output logic [uetd_pkg::OffsetWidth-1:0]   offsets [uetd_pkg::NumOffsets]
);

	logic                               busy_q;
	logic [uetd_pkg::IdxWidth-1:0]      idx_q;
	logic [uetd_pkg::StepWidth-1:0]     step_q;
	logic [uetd_pkg::BaudWidth-1:0]     rem_q;
	logic [uetd_pkg::OffsetWidth-1:0]   dvd_q;
	logic [uetd_pkg::OffsetWidth-1:0]   quo_q;
	logic [uetd_pkg::BaudWidth-1:0]     div_q;
	logic [uetd_pkg::OffsetWidth-1:0]   off_q [uetd_pkg::NumOffsets];

	logic [uetd_pkg::BaudWidth:0]       shifted;
	logic                               ge;
	logic [uetd_pkg::BaudWidth:0]       diff;
	logic [uetd_pkg::OffsetWidth-1:0]   quo_n;
	logic [uetd_pkg::IdxWidth-1:0]      idx_n;

	always_comb begin
		shifted = {rem_q, dvd_q[uetd_pkg::OffsetWidth-1]};
		ge      = shifted >= {1'b0, div_q};
		diff    = shifted - {1'b0, div_q};
		quo_n   = {quo_q[uetd_pkg::OffsetWidth-2:0], ge};
		idx_n   = idx_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			step_q <= '0;
			off_q  <= uetd_pkg::ResetOffset;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == uetd_pkg::StepWidth'(uetd_pkg::DivSteps - 1)) begin
				off_q[idx_q] <= quo_n;
				step_q       <= '0;
				if (idx_q == uetd_pkg::IdxWidth'(uetd_pkg::NumOffsets - 1)) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_n;
				end
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= uetd_pkg::OffsetDividend[0];
			div_q <= (baud == '0) ? uetd_pkg::BaudWidth'(1) : baud;
		end else if (busy_q) begin
			if (step_q == uetd_pkg::StepWidth'(uetd_pkg::DivSteps - 1)) begin
				rem_q <= '0;
				quo_q <= '0;
				if (idx_q != uetd_pkg::IdxWidth'(uetd_pkg::NumOffsets - 1)) begin
					dvd_q <= uetd_pkg::OffsetDividend[idx_n];
				end
			end else begin
				rem_q <= ge ? diff[uetd_pkg::BaudWidth-1:0] : shifted[uetd_pkg::BaudWidth-1:0];
				quo_q <= quo_n;
				dvd_q <= {dvd_q[uetd_pkg::OffsetWidth-2:0], 1'b0};
			end
		end
	end

	assign busy    = busy_q;
	assign offsets = off_q;

endmodule

/* sv/uetd_decode_core.sv */
// Input register and per-edge decode: sampling, byte completion, spacing and flush.
// Produces up to two result words per edge for the result queue.
// Depends on uetd_pkg.
module uetd_decode_core #(
	parameter int MAX_BYTES = uetd_pkg::DefMaxBytes
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               edge_valid,
	output logic                               edge_stall,
	input  logic [uetd_pkg::TimeWidth-1:0]     edge_time,
	input  logic                               capture_end,
	input  logic                               hold,
	input  logic [uetd_pkg::OffsetWidth-1:0]   offsets [uetd_pkg::NumOffsets],
	input  logic                               room,
	output uetd_pkg::push_t                    push
);

	localparam int EW = $clog2(MAX_BYTES + 1);

	logic                            v_s1;
	logic [uetd_pkg::TimeWidth-1:0]  t_s1;
	logic                            last_s1;

	logic [uetd_pkg::TimeWidth-1:0]  start_q, prev_q, min_q, max_q;
	logic                            parity_q, active_q, seen_q;
	logic [7:0]                      sampled_q, acc_q;
	logic [EW-1:0]                   emitted_q;

	logic [uetd_pkg::TimeWidth-1:0]  start_n, min_n, max_n;
	logic                            parity_n, active_n, seen_n;
	logic [7:0]                      sampled_n, acc_n;
	logic [EW-1:0]                   emitted_n;

	logic                            adv, accept;
	uetd_pkg::push_t                 push_c;

	assign adv        = v_s1 && room;
	assign edge_stall = hold || (v_s1 && !room);
	assign accept     = edge_valid && !edge_stall;

	always_comb begin
		logic [7:0]                     hit, hit_b, sampled_a, acc_a;
		logic [uetd_pkg::TimeWidth-1:0] lim, stop_lim, gap;
		logic                           first;
		uetd_pkg::result_t              fl;

		for (int i = 0; i < 8; i++) begin
			lim      = start_q + {8'd0, offsets[i]};
			hit[i]   = !sampled_q[i] && (t_s1 > lim);
			lim      = t_s1 + {8'd0, offsets[i]};
			hit_b[i] = t_s1 > lim;
		end
		stop_lim  = start_q + {8'd0, offsets[uetd_pkg::NumOffsets-1]};
		sampled_a = sampled_q | hit;
		acc_a     = parity_q ? acc_q : (acc_q | hit);
		gap       = t_s1 - prev_q;
		first     = 1'b0;
		fl        = '0;

		start_n   = start_q;
		parity_n  = parity_q;
		sampled_n = sampled_q;
		acc_n     = acc_q;
		active_n  = active_q;
		emitted_n = emitted_q;
		min_n     = min_q;
		max_n     = max_q;
		seen_n    = seen_q;
		push_c    = '0;

		if (active_q) begin
			sampled_n = sampled_a;
			acc_n     = acc_a;
			if (!parity_q && (t_s1 >= stop_lim)) begin
				active_n  = 1'b0;
				emitted_n = emitted_q + 1'b1;
				if (32'(emitted_n) < 32'(uetd_pkg::SpacingLimit)) begin
					first = (32'(emitted_n) == 32'd1);
					if (first || gap < min_q) begin
						min_n = gap;
					end
					if (first || gap > max_q) begin
						max_n = gap;
					end
					seen_n = 1'b1;
				end
				push_c.count = 2'd1;
				push_c.r0    = '{data_byte: acc_a | ~sampled_a, byte_valid: 1'b1,
					end_of_capture: 1'b0, min_spacing: min_n, max_spacing: max_n,
					spacing_seen: seen_n};
				if (32'(emitted_n) < 32'(MAX_BYTES)) begin
					start_n   = t_s1;
					sampled_n = hit_b;
					acc_n     = hit_b;
					active_n  = 1'b1;
					parity_n  = 1'b1;
				end
			end else begin
				parity_n = ~parity_q;
			end
		end else if (emitted_q == '0) begin
			start_n   = t_s1;
			sampled_n = hit_b;
			acc_n     = hit_b;
			active_n  = 1'b1;
			parity_n  = 1'b1;
		end

		if (last_s1) begin
			fl = '{data_byte: 8'd0, byte_valid: 1'b0, end_of_capture: 1'b1,
				min_spacing: min_n, max_spacing: max_n, spacing_seen: seen_n};
			if (active_n) begin
				fl.data_byte  = acc_n | ~sampled_n;
				fl.byte_valid = 1'b1;
			end
			if (active_n || push_c.count == 2'd0) begin
				if (push_c.count == 2'd1) begin
					push_c.r1    = fl;
					push_c.count = 2'd2;
				end else begin
					push_c.r0    = fl;
					push_c.count = 2'd1;
				end
			end else begin
				push_c.r0.end_of_capture = 1'b1;
			end
			start_n   = '0;
			parity_n  = 1'b0;
			sampled_n = '0;
			acc_n     = '0;
			active_n  = 1'b0;
			emitted_n = '0;
			min_n     = '0;
			max_n     = '0;
			seen_n    = 1'b0;
		end
		if (!adv) begin
			push_c.count = 2'd0;
		end
	end

	assign push = push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			start_q   <= '0;
			prev_q    <= '0;
			parity_q  <= 1'b0;
			sampled_q <= '0;
			acc_q     <= '0;
			active_q  <= 1'b0;
			emitted_q <= '0;
			min_q     <= '0;
			max_q     <= '0;
			seen_q    <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				start_q   <= start_n;
				prev_q    <= last_s1 ? '0 : t_s1;
				parity_q  <= parity_n;
				sampled_q <= sampled_n;
				acc_q     <= acc_n;
				active_q  <= active_n;
				emitted_q <= emitted_n;
				min_q     <= min_n;
				max_q     <= max_n;
				seen_q    <= seen_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_s1    <= edge_time;
			last_s1 <= capture_end;
		end
	end

endmodule

/* sv/uetd_result_fifo.sv */
// Four-word result queue that takes up to two words a cycle and gives one.
// Reports room when at least two entries are free.
// Depends on uetd_pkg.
module uetd_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  uetd_pkg::push_t   push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output uetd_pkg::result_t out_word
);

	uetd_pkg::result_t mem_q [4];
	logic [1:0]        wptr_q, rptr_q;
	logic [2:0]        count_q;
	logic              pop;

	assign out_valid = count_q != 3'd0;
	assign pop       = out_valid && !out_stall;
	assign room      = count_q <= 3'd2;
	assign out_word  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + push.count;
			rptr_q  <= rptr_q + 2'(pop);
			count_q <= count_q + 3'(push.count) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wptr_q + 2'd1] <= push.r1;
		end
	end

endmodule

/* sv/uart_edge_timestamp_decoder.sv */
// Top level of the UART edge timestamp decoder: decode core, result queue, offset divider.
// Depends on uetd_pkg, uetd_offset_div, uetd_decode_core and uetd_result_fifo.
//
//   channel  handshake                   payload
//   edge     edge_valid / edge_stall     edge_time, capture_end
//   result   result_valid / result_stall data_byte, byte_valid, end_of_capture,
//                                        min_spacing, max_spacing, spacing_seen
//   baud     baud_valid / baud_ready     baud_rate
//
// One edge is taken per cycle while edge_stall is low; its words pass through the input
// register and then the result queue to the result port. A baud rate write recomputes the
// offsets on the serial divider, during which edges are stalled and further writes are not taken.
// Reset loads the offsets for 10400 baud at once and clears all capture state.
// Otherwise edges stall only while an edge is held and the four-word result queue has
// fewer than two free entries.
module uart_edge_timestamp_decoder #(
	parameter int MAX_BYTES = uetd_pkg::DefMaxBytes
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               edge_valid,
	output logic                               edge_stall,
	input  logic [uetd_pkg::TimeWidth-1:0]     edge_time,
	input  logic                               capture_end,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [7:0]                         data_byte,
	output logic                               byte_valid,
	output logic                               end_of_capture,
	output logic [uetd_pkg::TimeWidth-1:0]     min_spacing,
	output logic [uetd_pkg::TimeWidth-1:0]     max_spacing,
	output logic                               spacing_seen,
	input  logic                               baud_valid,
	output logic                               baud_ready,
	input  logic [uetd_pkg::BaudWidth-1:0]     baud_rate
);

	logic                             div_busy;
	logic [uetd_pkg::OffsetWidth-1:0] offsets [uetd_pkg::NumOffsets];
	logic                             room;
	uetd_pkg::push_t                  push;
	uetd_pkg::result_t                word;

	assign baud_ready = !div_busy;

	uetd_offset_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (baud_valid && baud_ready),
		.baud    (baud_rate),
		.busy    (div_busy),
		.offsets (offsets)
	);

	uetd_decode_core #(
		.MAX_BYTES (MAX_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.edge_valid  (edge_valid),
		.edge_stall  (edge_stall),
		.edge_time   (edge_time),
		.capture_end (capture_end),
		.hold        (div_busy),
		.offsets     (offsets),
		.room        (room),
		.push        (push)
	);

	uetd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_word  (word)
	);

	assign data_byte      = word.data_byte;
	assign byte_valid     = word.byte_valid;
	assign end_of_capture = word.end_of_capture;
	assign min_spacing    = word.min_spacing;
	assign max_spacing    = word.max_spacing;
	assign spacing_seen   = word.spacing_seen;

endmodule

/* test/tb_uart_edge_timestamp_decoder.sv */
// Testbench for uart_edge_timestamp_decoder: a directed table of edges, then random 8N1 captures
// and noise over several baud rates, each result word checked against a decoder model kept here
// or against the word given in the table. Depends on uetd_pkg and the decoder RTL.
module tb_uart_edge_timestamp_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxBytes   = uetd_pkg::DefMaxBytes;
	localparam int NumPhases  = 7;
	localparam int LongPhase  = 4;
	localparam int PhaseItems = 130;
	localparam int NumRows    = 24;

	typedef struct packed {
		logic [uetd_pkg::TimeWidth-1:0] t;
		logic                           last;
		logic                           typed;
		uetd_pkg::result_t              want;
	} edge_row_t;

	localparam uetd_pkg::result_t NoWord = '0;
	localparam uetd_pkg::result_t FlushAllOnes = '{data_byte: 8'hFF, byte_valid: 1'b1,
		end_of_capture: 1'b1, min_spacing: '0, max_spacing: '0, spacing_seen: 1'b0};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           edge_valid = 1'b0;
	logic                           edge_stall;
	logic [uetd_pkg::TimeWidth-1:0] edge_time = '0;
	logic                           capture_end = 1'b0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	logic [7:0]                     data_byte;
	logic                           byte_valid;
	logic                           end_of_capture;
	logic [uetd_pkg::TimeWidth-1:0] min_spacing;
	logic [uetd_pkg::TimeWidth-1:0] max_spacing;
	logic                           spacing_seen;
	logic                           baud_valid = 1'b0;
	logic                           baud_ready;
	logic [uetd_pkg::BaudWidth-1:0] baud_rate = '0;

	logic                 row_typed = 1'b0;
	uetd_pkg::result_t    row_want = '0;

	int send_idle = 21;
	int recv_idle = 45;
	int gen_baud = uetd_pkg::ResetBaud;
	int errors = 0;
	int edges_taken = 0;
	int words_checked = 0;

	logic [31:0] line_offset [uetd_pkg::NumOffsets];
	logic [31:0] frame_start;
	logic [31:0] last_edge_at;
	logic        next_parity;
	logic [7:0]  sampled_mask;
	logic [7:0]  shift_acc;
	logic        frame_open;
	int          frames_done;
	logic [31:0] gap_min;
	logic [31:0] gap_max;
	logic        gap_seen;

	uetd_pkg::result_t decoded [2];
	int                decoded_n;
	uetd_pkg::result_t pending [$];
	edge_row_t         plan [$];
	edge_row_t         directed_rows [NumRows];

	uart_edge_timestamp_decoder #(
		.MAX_BYTES(MaxBytes)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.edge_valid(edge_valid),
		.edge_stall(edge_stall),
		.edge_time(edge_time),
		.capture_end(capture_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.data_byte(data_byte),
		.byte_valid(byte_valid),
		.end_of_capture(end_of_capture),
		.min_spacing(min_spacing),
		.max_spacing(max_spacing),
		.spacing_seen(spacing_seen),
		.baud_valid(baud_valid),
		.baud_ready(baud_ready),
		.baud_rate(baud_rate)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic load_offsets(input logic [uetd_pkg::BaudWidth-1:0] rate);
		int unsigned b;
		b = (rate == 0) ? 1 : rate;
		for (int i = 0; i < 8; i++) begin
			line_offset[i] = (i * 1000000 + 1500000) / b;
		end
		line_offset[8] = 9500000 / b;
	endtask

	task automatic clear_frame_state();
		frame_start = '0;
		last_edge_at = '0;
		next_parity = 1'b0;
		sampled_mask = '0;
		shift_acc = '0;
		frame_open = 1'b0;
		frames_done = 0;
		gap_min = '0;
		gap_max = '0;
		gap_seen = 1'b0;
	endtask

	task automatic sample_line(input logic [31:0] t, input logic level_high);
		logic [31:0] lim;
		for (int i = 0; i < 8; i++) begin
			lim = frame_start + line_offset[i];
			if (!sampled_mask[i] && t > lim) begin
				sampled_mask[i] = 1'b1;
				if (level_high) begin
					shift_acc[i] = 1'b1;
				end
			end
		end
	endtask

	task automatic open_frame(input logic [31:0] t);
		frame_start = t;
		shift_acc = '0;
		sampled_mask = '0;
		frame_open = 1'b1;
		sample_line(t, 1'b1);
		next_parity = 1'b1;
	endtask

	function automatic uetd_pkg::result_t make_word(input logic [7:0] data, input logic valid);
		uetd_pkg::result_t w;
		w.data_byte = data;
		w.byte_valid = valid;
		w.end_of_capture = 1'b0;
		w.min_spacing = gap_min;
		w.max_spacing = gap_max;
		w.spacing_seen = gap_seen;
		return w;
	endfunction

	task automatic decode_edge(input logic [31:0] t, input logic last);
		logic        p;
		logic [31:0] lim;
		logic [31:0] gap;
		decoded_n = 0;
		if (frame_open) begin
			p = next_parity;
			sample_line(t, !p);
			lim = frame_start + line_offset[8];
			if (!p && t >= lim) begin
				frame_open = 1'b0;
				frames_done++;
				if (frames_done < uetd_pkg::SpacingLimit) begin
					gap = t - last_edge_at;
					if (frames_done == 1 || gap < gap_min) begin
						gap_min = gap;
					end
					if (frames_done == 1 || gap > gap_max) begin
						gap_max = gap;
					end
					gap_seen = 1'b1;
				end
				decoded[decoded_n] = make_word(shift_acc | ~sampled_mask, 1'b1);
				decoded_n++;
				if (frames_done < MaxBytes) begin
					open_frame(t);
				end
			end else begin
				next_parity = ~next_parity;
			end
		end else if (frames_done == 0) begin
			open_frame(t);
		end
		last_edge_at = t;
		if (last) begin
			if (frame_open) begin
				decoded[decoded_n] = make_word(shift_acc | ~sampled_mask, 1'b1);
				decoded_n++;
			end
			if (decoded_n == 0) begin
				decoded[0] = make_word(8'h00, 1'b0);
				decoded_n = 1;
			end
			decoded[decoded_n - 1].end_of_capture = 1'b1;
			clear_frame_state();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		uetd_pkg::result_t got;
		uetd_pkg::result_t want;
		if (arst_n && edge_valid && !edge_stall) begin
			decode_edge(edge_time, capture_end);
			edges_taken++;
			if (row_typed) begin
				pending.push_back(row_want);
			end else begin
				for (int k = 0; k < decoded_n; k++) begin
					pending.push_back(decoded[k]);
				end
			end
		end
		if (arst_n && result_valid && !result_stall) begin
			got = '{data_byte, byte_valid, end_of_capture, min_spacing, max_spacing, spacing_seen};
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, expected none, got %h", $time, got);
			end else begin
				want = pending.pop_front();
				check_field("data_byte", want.data_byte, got.data_byte);
				check_field("byte_valid", want.byte_valid, got.byte_valid);
				check_field("end_of_capture", want.end_of_capture, got.end_of_capture);
				check_field("min_spacing", want.min_spacing, got.min_spacing);
				check_field("max_spacing", want.max_spacing, got.max_spacing);
				check_field("spacing_seen", want.spacing_seen, got.spacing_seen);
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	task automatic send_row(input edge_row_t row);
		while ($urandom_range(0, 99) < send_idle) begin
			edge_valid <= 1'b0;
			@(posedge clk);
		end
		edge_valid <= 1'b1;
		edge_time <= row.t;
		capture_end <= row.last;
		row_typed <= row.typed;
		row_want <= row.want;
		do @(posedge clk); while (edge_stall);
	endtask

	task automatic wait_idle();
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_baud(input logic [uetd_pkg::BaudWidth-1:0] rate);
		baud_valid <= 1'b1;
		baud_rate <= rate;
		do @(posedge clk); while (!baud_ready);
		baud_valid <= 1'b0;
		load_offsets(rate);
		gen_baud = (rate == 0) ? 1 : rate;
	endtask

	task automatic push_edge(input logic [31:0] t, input logic last);
		plan.push_back('{t, last, 1'b0, NoWord});
	endtask

	task automatic mark_end();
		edge_row_t e;
		e = plan.pop_back();
		e.last = 1'b1;
		plan.push_back(e);
	endtask

	task automatic gen_frames(input int nbytes, input logic long_run);
		logic [31:0] t0;
		logic [7:0]  data;
		logic        lvl;
		logic        level;
		int          per;
		int          jit;
		int          first;
		int          r;
		int          drop;
		per = 1000000 / gen_baud;
		jit = per / 16;
		if ($urandom_range(0, 7) == 0) begin
			t0 = 32'hFFFFFFFF - $urandom_range(0, 20 * per + 20);
		end else begin
			t0 = $urandom;
		end
		first = plan.size();
		for (int n = 0; n < nbytes; n++) begin
			r = $urandom_range(0, 9);
			if (long_run) begin
				data = (r != 0) ? 8'hFF : 8'($urandom);
			end else begin
				data = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
			end
			push_edge(t0, 1'b0);
			level = 1'b0;
			for (int k = 1; k <= 9; k++) begin
				lvl = (k <= 8) ? data[k - 1] : 1'b1;
				if (lvl != level) begin
					push_edge(t0 + (k * 1000000) / gen_baud + $urandom_range(0, jit), 1'b0);
					level = lvl;
				end
			end
			if ($urandom_range(0, 5) == 0) begin
				t0 = t0 + ((95 + $urandom_range(0, 2)) * 100000) / gen_baud;
			end else begin
				t0 = t0 + ((95 + $urandom_range(0, 60)) * 100000) / gen_baud;
			end
		end
		r = $urandom_range(0, 3);
		if (!long_run && r == 0 && plan.size() - first > 1) begin
			drop = $urandom_range(1, (plan.size() - first - 1 < 4) ? plan.size() - first - 1 : 4);
			repeat (drop) void'(plan.pop_back());
			mark_end();
		end else if (!long_run && r == 1) begin
			mark_end();
		end else begin
			push_edge(t0, 1'b1);
		end
	endtask

	task automatic gen_noise();
		logic [31:0] t;
		int          n;
		int          per;
		per = 1000000 / gen_baud + 1;
		n = $urandom_range(2, 12);
		t = $urandom;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				t = $urandom;
			end else begin
				t = t + $urandom_range(0, 3 * per);
			end
			push_edge(t, (i == n - 1) || ($urandom_range(0, 15) == 0));
		end
	endtask

	initial begin
		logic [uetd_pkg::BaudWidth-1:0] rate;
		directed_rows = '{
			'{32'd0,          1'b1, 1'b1, FlushAllOnes},
			'{32'hFFFFFFFF,   1'b1, 1'b1, FlushAllOnes},
			'{32'd1000,       1'b0, 1'b0, NoWord},
			'{32'd1870,       1'b0, 1'b0, NoWord},
			'{32'd2000,       1'b1, 1'b0, NoWord},
			'{32'd5000,       1'b0, 1'b0, NoWord},
			'{32'd5096,       1'b0, 1'b0, NoWord},
			'{32'd5192,       1'b0, 1'b0, NoWord},
			'{32'd5288,       1'b0, 1'b0, NoWord},
			'{32'd5384,       1'b0, 1'b0, NoWord},
			'{32'd5480,       1'b0, 1'b0, NoWord},
			'{32'd5576,       1'b0, 1'b0, NoWord},
			'{32'd5673,       1'b0, 1'b0, NoWord},
			'{32'd5769,       1'b0, 1'b0, NoWord},
			'{32'd5865,       1'b0, 1'b0, NoWord},
			'{32'd6000,       1'b1, 1'b0, NoWord},
			'{32'hFFFFFF00,   1'b0, 1'b0, NoWord},
			'{32'hFFFFFF10,   1'b0, 1'b0, NoWord},
			'{32'hFFFFFF20,   1'b1, 1'b0, NoWord},
			'{32'd7000,       1'b0, 1'b0, NoWord},
			'{32'd7100,       1'b1, 1'b0, NoWord},
			'{32'd20000,      1'b0, 1'b0, NoWord},
			'{32'd20000,      1'b0, 1'b0, NoWord},
			'{32'd20000,      1'b1, 1'b0, NoWord}
		};
		clear_frame_state();
		load_offsets(uetd_pkg::ResetBaud);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NumRows; i++) begin
			send_row(directed_rows[i]);
		end
		edge_valid <= 1'b0;
		for (int ph = 0; ph < NumPhases; ph++) begin
			case (ph * 3 / NumPhases)
				0: begin
					send_idle = 21;
					recv_idle = 45;
				end
				1: begin
					send_idle = 45;
					recv_idle = 21;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			case (ph)
				0: rate = 20'd9600;
				1: rate = 20'd1000000;
				2: rate = 20'd1;
				3: rate = 20'd0;
				4: rate = 20'd115200;
				5: rate = 20'hFFFFF;
				default: rate = 20'($urandom_range(1, 1000000));
			endcase
			wait_idle();
			write_baud(rate);
			plan.delete();
			if (ph == LongPhase) begin
				gen_frames(MaxBytes + 2, 1'b1);
			end
			while (plan.size() < PhaseItems) begin
				if ($urandom_range(0, 9) < 7) begin
					gen_frames($urandom_range(1, 6), 1'b0);
				end else begin
					gen_noise();
				end
			end
			while (plan.size() != 0) begin
				send_row(plan.pop_front());
			end
			edge_valid <= 1'b0;
		end
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Decoded %0d edges across %0d baud settings, including a capture past the byte limit.",
			edges_taken, NumPhases + 1);
		$display("Checked %0d result words with %0d mismatches.", words_checked, errors);
		if (errors == 0) begin
			$display("uart_edge_timestamp_decoder verification clean");
		end else begin
			$display("uart_edge_timestamp_decoder verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("uart_edge_timestamp_decoder verification failed");
		$finish;
	end

endmodule

/* sim.f */
sv/uetd_pkg.sv
sv/uetd_offset_div.sv
sv/uetd_decode_core.sv
sv/uetd_result_fifo.sv
sv/uart_edge_timestamp_decoder.sv
test/tb_uart_edge_timestamp_decoder.sv
